// ===== sv/dbtn_pkg.sv =====
// Shared types and constants for the debounced button reader.
// Event codes, configuration register indexes and reset values.
// No dependencies.
package dbtn_pkg;

  localparam int unsigned BTN_BITS = 4;
  localparam int unsigned NOW_BITS = 32;
  localparam int unsigned CFG_BITS = 16;
  localparam int unsigned CFG_INDEX_BITS = 1;

  typedef logic [BTN_BITS-1:0] btn_t;
  typedef logic [CFG_BITS-1:0] cfg_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_LEFT    = 3'd1,
    EV_RIGHT   = 3'd2,
    EV_ROTATE  = 3'd3,
    EV_DOWN    = 3'd4,
    EV_RESTART = 3'd5
  } event_t;

  localparam cfg_index_t REG_DEBOUNCE = 1'd0;
  localparam cfg_index_t REG_REPEAT   = 1'd1;

  localparam cfg_t DEBOUNCE_RESET = 16'd40;
  localparam cfg_t REPEAT_RESET   = 16'd180;

  localparam int unsigned BTN_LEFT   = 0;
  localparam int unsigned BTN_RIGHT  = 1;
  localparam int unsigned BTN_ROTATE = 2;
  localparam int unsigned BTN_DOWN   = 3;

endpackage

// ===== sv/debounced_buttons_with_autorepeat.sv =====
// Top level of the debounced button reader with restart combo and auto-repeat.
// Holds the sample register, result register and configuration registers.
// Depends on dbtn_pkg and dbtn_core.
//
// Usage:
//   Poll channel (poll_valid/poll_stall) carries one word per poll: the raw
//   button levels and the current millisecond time. Event channel
//   (event_valid/event_stall) returns exactly one event code per poll, in order.
//   event_valid rises once a poll has passed the sample and result registers;
//   one poll is taken every cycle unless poll_stall is high.
//   A stalled event word holds in the result register while the sample
//   register still takes one more poll; poll_stall rises only when both
//   are full and the receiver stalls.
//   Configuration writes (cfg_write, cfg_index, cfg_data) land at the clock
//   edge; index 0 is the debounce time, index 1 the repeat interval.
//   Write them only while no poll is in flight.
//   Reset clears all button state and times, empties both registers and
//   loads a 40 ms debounce and a 180 ms repeat interval.
module debounced_buttons_with_autorepeat #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          poll_valid,
  output logic                          poll_stall,
  input  logic [3:0]                    raw_buttons,
  input  logic [dbtn_pkg::NOW_BITS-1:0] now_ms,
  output logic                          event_valid,
  input  logic                          event_stall,
  output logic [2:0]                    event_code,
  input  logic                          cfg_write,
  input  dbtn_pkg::cfg_index_t          cfg_index,
  input  dbtn_pkg::cfg_t                cfg_data
);

  dbtn_pkg::cfg_t                settle_limit;
  dbtn_pkg::cfg_t                repeat_ms;
  logic                          sample_full;
  dbtn_pkg::btn_t                sample_raw;
  logic [dbtn_pkg::NOW_BITS-1:0] sample_now;
  logic                          advance;
  logic                          accept;
  logic                          step;
  dbtn_pkg::event_t              code;

  assign advance    = !event_valid || !event_stall;
  assign poll_stall = sample_full && !advance;
  assign accept     = poll_valid && !poll_stall;
  assign step       = sample_full && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_limit <= dbtn_pkg::DEBOUNCE_RESET;
      repeat_ms    <= dbtn_pkg::REPEAT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dbtn_pkg::REG_DEBOUNCE: begin
          settle_limit <= cfg_data;
        end
        dbtn_pkg::REG_REPEAT: begin
          repeat_ms <= cfg_data;
        end
        default: begin
          settle_limit <= settle_limit;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_full <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      if (accept) begin
        sample_full <= 1'b1;
      end else if (advance) begin
        sample_full <= 1'b0;
      end
      if (advance) begin
        event_valid <= sample_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_raw <= raw_buttons;
      sample_now <= now_ms;
    end
    if (step) begin
      event_code <= code;
    end
  end

  dbtn_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .raw          (sample_raw),
    .now          (sample_now),
    .settle_limit (settle_limit),
    .repeat_ms    (repeat_ms),
    .code         (code)
  );

endmodule

// ===== sv/dbtn_core.sv =====
// Debounce state, edge detection, restart combo and down auto-repeat.
// Computes one event per step from the registered sample and updates state.
// Depends on dbtn_pkg.
module dbtn_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  dbtn_pkg::btn_t                  raw,
  input  logic [dbtn_pkg::NOW_BITS-1:0]   now,
  input  dbtn_pkg::cfg_t                  settle_limit,
  input  dbtn_pkg::cfg_t                  repeat_ms,
  output dbtn_pkg::event_t                code
);

  dbtn_pkg::btn_t       last_raw;
  dbtn_pkg::btn_t       stable_buttons;
  logic [TIME_BITS-1:0] change_time;
  logic [TIME_BITS-1:0] down_repeat_time;
  logic                 combo_latched;

  dbtn_pkg::btn_t       stable_next;
  dbtn_pkg::btn_t       edges;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] change_time_next;
  logic [TIME_BITS-1:0] settle_elapsed;
  logic [TIME_BITS-1:0] repeat_elapsed;
  logic [TIME_BITS-1:0] down_repeat_time_next;
  logic                 combo_latched_next;

  assign now_t            = TIME_BITS'({32'd0, now});
  assign change_time_next = (raw != last_raw) ? now_t : change_time;
  assign settle_elapsed   = now_t - change_time_next;
  assign repeat_elapsed   = now_t - down_repeat_time;

  always_comb begin
    stable_next = stable_buttons;
    if (settle_elapsed >= TIME_BITS'(settle_limit)) begin
      stable_next = raw;
    end
    edges = stable_next & ~stable_buttons;
    code = dbtn_pkg::EV_NONE;
    combo_latched_next = 1'b0;
    down_repeat_time_next = down_repeat_time;
    if (stable_next[dbtn_pkg::BTN_ROTATE] && stable_next[dbtn_pkg::BTN_DOWN]) begin
      combo_latched_next = 1'b1;
      if (!combo_latched) begin
        code = dbtn_pkg::EV_RESTART;
      end
    end else if (edges[dbtn_pkg::BTN_LEFT]) begin
      code = dbtn_pkg::EV_LEFT;
    end else if (edges[dbtn_pkg::BTN_RIGHT]) begin
      code = dbtn_pkg::EV_RIGHT;
    end else if (edges[dbtn_pkg::BTN_ROTATE]) begin
      code = dbtn_pkg::EV_ROTATE;
    end else if (edges[dbtn_pkg::BTN_DOWN] ||
                 (stable_next[dbtn_pkg::BTN_DOWN] &&
                  repeat_elapsed >= TIME_BITS'(repeat_ms))) begin
      code = dbtn_pkg::EV_DOWN;
      down_repeat_time_next = now_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw         <= '0;
      stable_buttons   <= '0;
      change_time      <= '0;
      down_repeat_time <= '0;
      combo_latched    <= 1'b0;
    end else if (step) begin
      last_raw         <= raw;
      stable_buttons   <= stable_next;
      change_time      <= change_time_next;
      down_repeat_time <= down_repeat_time_next;
      combo_latched    <= combo_latched_next;
    end
  end

endmodule

// ===== test/testbench.sv =====
// Testbench for the debounced button reader with restart combo and auto-repeat.
// Sends directed and random polls, checks events against table codes or an in-bench model.
// Depends on dbtn_pkg and debounced_buttons_with_autorepeat.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    dbtn_pkg::btn_t   raw;
    logic [31:0]      now;
    logic             typed;
    dbtn_pkg::event_t want;
  } poll_row_t;

  localparam int DIRECTED_ROWS = 26;
  localparam poll_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{4'h0, 32'd0,          1'b1, dbtn_pkg::EV_NONE},
    '{4'h1, 32'd100,        1'b1, dbtn_pkg::EV_NONE},
    '{4'h1, 32'd140,        1'b1, dbtn_pkg::EV_LEFT},
    '{4'h0, 32'd141,        1'b0, dbtn_pkg::EV_NONE},
    '{4'h0, 32'd181,        1'b0, dbtn_pkg::EV_NONE},
    '{4'h2, 32'd300,        1'b0, dbtn_pkg::EV_NONE},
    '{4'h2, 32'd340,        1'b1, dbtn_pkg::EV_RIGHT},
    '{4'h4, 32'd400,        1'b0, dbtn_pkg::EV_NONE},
    '{4'h4, 32'd440,        1'b1, dbtn_pkg::EV_ROTATE},
    '{4'h8, 32'd500,        1'b0, dbtn_pkg::EV_NONE},
    '{4'h8, 32'd540,        1'b1, dbtn_pkg::EV_DOWN},
    '{4'h8, 32'd720,        1'b0, dbtn_pkg::EV_NONE},
    '{4'h8, 32'd721,        1'b0, dbtn_pkg::EV_NONE},
    '{4'hC, 32'd800,        1'b0, dbtn_pkg::EV_NONE},
    '{4'hC, 32'd840,        1'b1, dbtn_pkg::EV_RESTART},
    '{4'hC, 32'd900,        1'b0, dbtn_pkg::EV_NONE},
    '{4'hF, 32'd1000,       1'b0, dbtn_pkg::EV_NONE},
    '{4'hF, 32'd1040,       1'b0, dbtn_pkg::EV_NONE},
    '{4'h7, 32'd1100,       1'b0, dbtn_pkg::EV_NONE},
    '{4'h0, 32'd1200,       1'b0, dbtn_pkg::EV_NONE},
    '{4'h0, 32'd1240,       1'b0, dbtn_pkg::EV_NONE},
    '{4'hB, 32'd1300,       1'b0, dbtn_pkg::EV_NONE},
    '{4'hB, 32'd1340,       1'b1, dbtn_pkg::EV_LEFT},
    '{4'h8, 32'hFFFF_FFF0, 1'b0, dbtn_pkg::EV_NONE},
    '{4'h8, 32'h0000_0020, 1'b0, dbtn_pkg::EV_NONE},
    '{4'h8, 32'h0000_0005, 1'b0, dbtn_pkg::EV_NONE}
  };

  localparam int PHASES = 6;
  localparam int PHASE_POLLS = 265;
  localparam dbtn_pkg::cfg_t PHASE_DEBOUNCE [PHASES] =
    '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd40, 16'd0};
  localparam dbtn_pkg::cfg_t PHASE_REPEAT [PHASES] =
    '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd180, 16'd0};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 poll_valid = 1'b0;
  logic                 poll_stall;
  dbtn_pkg::btn_t       raw_buttons = '0;
  logic [31:0]          now_ms = '0;
  logic                 event_valid;
  logic                 event_stall = 1'b0;
  logic [2:0]           event_code;
  logic                 cfg_write = 1'b0;
  dbtn_pkg::cfg_index_t cfg_index = dbtn_pkg::REG_DEBOUNCE;
  dbtn_pkg::cfg_t       cfg_data = '0;

  debounced_buttons_with_autorepeat DUT (
    .clk         (clk),
    .rst         (rst),
    .poll_valid  (poll_valid),
    .poll_stall  (poll_stall),
    .raw_buttons (raw_buttons),
    .now_ms      (now_ms),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_code  (event_code),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // reader model state
  dbtn_pkg::btn_t seen_raw = '0;
  dbtn_pkg::btn_t settled = '0;
  dbtn_pkg::btn_t settled_prev = '0;
  logic [31:0]    change_at = '0;
  logic [31:0]    repeat_at = '0;
  logic           combo_held = 1'b0;
  dbtn_pkg::cfg_t debounce_cfg = dbtn_pkg::DEBOUNCE_RESET;
  dbtn_pkg::cfg_t repeat_cfg = dbtn_pkg::REPEAT_RESET;

  dbtn_pkg::event_t pending_events [$];
  int     failures = 0;
  int     polls_sent = 0;
  int     settings_used = 0;
  int     holds_done = 0;
  int     events_seen [6] = '{default: 0};
  int     burst_left = 0;
  bit     hold_req = 1'b0;

  function automatic dbtn_pkg::event_t next_event(dbtn_pkg::btn_t raw, logic [31:0] now);
    dbtn_pkg::btn_t rises;
    if (raw != seen_raw) begin
      seen_raw = raw;
      change_at = now;
    end
    if (now - change_at >= 32'(debounce_cfg)) settled = seen_raw;
    rises = settled & ~settled_prev;
    settled_prev = settled;
    if (settled[dbtn_pkg::BTN_ROTATE] && settled[dbtn_pkg::BTN_DOWN]) begin
      if (combo_held) return dbtn_pkg::EV_NONE;
      combo_held = 1'b1;
      return dbtn_pkg::EV_RESTART;
    end
    combo_held = 1'b0;
    if (rises[dbtn_pkg::BTN_LEFT]) return dbtn_pkg::EV_LEFT;
    if (rises[dbtn_pkg::BTN_RIGHT]) return dbtn_pkg::EV_RIGHT;
    if (rises[dbtn_pkg::BTN_ROTATE]) return dbtn_pkg::EV_ROTATE;
    if (rises[dbtn_pkg::BTN_DOWN] ||
        (settled[dbtn_pkg::BTN_DOWN] && now - repeat_at >= 32'(repeat_cfg))) begin
      repeat_at = now;
      return dbtn_pkg::EV_DOWN;
    end
    return dbtn_pkg::EV_NONE;
  endfunction

  task automatic send_poll(dbtn_pkg::btn_t raw, logic [31:0] now, logic typed,
                           dbtn_pkg::event_t want);
    dbtn_pkg::event_t got;
    int gap;
    poll_valid <= 1'b1;
    raw_buttons <= raw;
    now_ms <= now;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    got = next_event(raw, now);
    pending_events.push_back(typed ? want : got);
    polls_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        poll_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain;
    poll_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timing(dbtn_pkg::cfg_t deb, dbtn_pkg::cfg_t rep);
    cfg_write <= 1'b1;
    cfg_index <= dbtn_pkg::REG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk);
    cfg_index <= dbtn_pkg::REG_REPEAT;
    cfg_data <= rep;
    @(posedge clk);
    cfg_write <= 1'b0;
    debounce_cfg = deb;
    repeat_cfg = rep;
    settings_used++;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : check_events
    dbtn_pkg::event_t want;
    if (!rst && event_valid && !event_stall) begin
      if (pending_events.size() == 0) begin
        $error("event_code: expected nothing, got %0d", event_code);
        failures++;
      end else begin
        want = pending_events.pop_front();
        events_seen[int'(want)]++;
        if (event_code !== 3'(want)) begin
          $error("event_code: expected %0d (%s), got %0d", want, want.name(), event_code);
          failures++;
        end
      end
    end
  end

  initial begin : event_receiver
    int tick;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        event_stall <= 1'b1;
        repeat (150) @(posedge clk);
        holds_done++;
      end
      tick++;
      case ((tick / 64) % 4)
        0: event_stall <= 1'b0;
        1: event_stall <= ($urandom_range(0, 3) == 0);
        2: event_stall <= ($urandom_range(0, 3) != 0);
        default: event_stall <= (tick % 3 == 0);
      endcase
    end
  end

  initial begin : poll_sender
    dbtn_pkg::btn_t held;
    logic [31:0]    clock_ms;
    int             span;
    dbtn_pkg::cfg_t deb;
    dbtn_pkg::cfg_t rep;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_poll(DIRECTED[i].raw, DIRECTED[i].now, DIRECTED[i].typed, DIRECTED[i].want);
    end
    drain();
    held = '0;
    clock_ms = $urandom();
    for (int phase = 0; phase < PHASES; phase++) begin
      deb = (phase == PHASES - 1) ? dbtn_pkg::cfg_t'($urandom_range(0, 300))
                                  : PHASE_DEBOUNCE[phase];
      rep = (phase == PHASES - 1) ? dbtn_pkg::cfg_t'($urandom_range(0, 400))
                                  : PHASE_REPEAT[phase];
      set_timing(deb, rep);
      span = ((deb > rep) ? int'(deb) : int'(rep)) / 3 + 2;
      for (int n = 0; n < PHASE_POLLS; n++) begin
        if (phase == 2 && n == 120) hold_req = 1'b1;
        if ($urandom_range(0, 5) == 0) begin
          held = ($urandom_range(0, 3) == 0) ? dbtn_pkg::btn_t'(4'hC | $urandom_range(0, 3))
                                             : dbtn_pkg::btn_t'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 39) == 0) clock_ms = $urandom();
        else clock_ms += 32'($urandom_range(0, span));
        send_poll(held, clock_ms, 1'b0, dbtn_pkg::EV_NONE);
      end
      drain();
    end
    $display("Covered %0d polls over %0d timing settings, %0d long receiver hold(s).",
             polls_sent, settings_used, holds_done);
    $display("Events: none %0d, left %0d, right %0d, rotate %0d, down %0d, restart %0d",
             events_seen[0], events_seen[1], events_seen[2], events_seen[3],
             events_seen[4], events_seen[5]);
    if (failures == 0 && pending_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
